### sv/bgtc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and lookup tables of the temperature-compensated
// battery gauge. No dependencies; every other file refers to it by scoped names.
package bgtc_pkg;

   // Field widths of the streams and the register port
   localparam int SAMPLE_W = 12;
   localparam int TEMP_W   = 7;
   localparam int PCT_W    = 7;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;
   localparam int REQ_W    = 2 * SAMPLE_W;
   localparam int RSP_W    = TEMP_W + PCT_W + 2;

   localparam int SAMPLE_PAIRS_DEF = 8;

   // Voltage ratio is Q0.16 and may reach 1.0, hence one extra bit
   localparam int RATIO_W   = 17;
   localparam int DIV_STEPS = RATIO_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam int FRAC_W    = 16;

   // Row values of the blend are Q16, the blended sum carries a factor of ten
   localparam int ROW_W     = 26;
   localparam int BLEND_W   = 32;
   localparam int BLEND_SH  = FRAC_W + 1;
   localparam int QUO_W     = BLEND_W - 1 - BLEND_SH;
   // floor(y / 5) = (y * DIV5_MUL) >> DIV5_SH for y below 81920
   localparam int DIV5_W    = 16;
   localparam logic [DIV5_W-1:0] DIV5_MUL = 16'd52429;
   localparam int DIV5_SH   = 18;
   localparam int PROD_W    = QUO_W + DIV5_W;

   // Register map (word index)
   localparam logic CSR_GREEN = 1'b0;
   localparam logic CSR_RED   = 1'b1;
   localparam logic [PCT_W-1:0] GREEN_RST = 7'd85;
   localparam logic [PCT_W-1:0] RED_RST   = 7'd20;

   localparam logic [PCT_W-1:0]  PCT_MAX  = 7'd100;
   localparam logic [TEMP_W-1:0] TEMP_MIN = TEMP_W'(-10);
   localparam logic [TEMP_W-1:0] TEMP_MAX = TEMP_W'(50);
   localparam logic [2:0] ROW_TOP   = 3'd5;
   localparam logic [3:0] WT_FULL   = 4'd10;
   localparam logic [2:0] SEG_LAST  = 3'd5;
   localparam logic [2:0] COL_LAST  = 3'd4;

   // Thermistor node codes, -10 C to 50 C in steps of 10 C
   localparam logic [SAMPLE_W-1:0] NTC_NODE [7] = '{
      12'd3375, 12'd3040, 12'd2656, 12'd2246, 12'd1849, 12'd1502, 12'd1191};
   // Battery node codes, 4.2 V down to 3.3 V
   localparam logic [SAMPLE_W-1:0] BAT_NODE [6] = '{
      12'd914, 12'd871, 12'd827, 12'd784, 12'd762, 12'd718};
   // Charge in percent, rows by temperature node, columns by battery node
   localparam logic [PCT_W-1:0] CHARGE_LUT [7][6] = '{
      '{7'd70,  7'd35, 7'd10, 7'd0,  7'd0, 7'd0},
      '{7'd80,  7'd50, 7'd20, 7'd5,  7'd0, 7'd0},
      '{7'd90,  7'd65, 7'd35, 7'd10, 7'd2, 7'd0},
      '{7'd100, 7'd80, 7'd50, 7'd18, 7'd5, 7'd0},
      '{7'd100, 7'd85, 7'd55, 7'd20, 7'd8, 7'd0},
      '{7'd100, 7'd86, 7'd56, 7'd22, 7'd9, 7'd0},
      '{7'd100, 7'd86, 7'd56, 7'd22, 7'd9, 7'd0}};

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEG, ST_TDIV, ST_BDIV, ST_MUL, ST_BLEND, ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accumulate;
      logic seg_load;
      logic tdiv_step;
      logic bdiv_load;
      logic bdiv_step;
      logic mul;
      logic blend;
      logic emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_pair;
      logic div_ge;
      logic out_busy;
   } status_type;

   // Datapath to divider
   typedef struct packed {
      logic load;
      logic step;
      logic shift;
   } div_cmd_type;

endpackage

### sv/bgtc_divider.sv
`timescale 1ns / 1ps
// Shared division unit: one compare-and-subtract per cycle while a step is
// commanded, either counting (small quotients) or shifting in one quotient bit. Uses bgtc_pkg.
module bgtc_divider #(
   parameter int REM_W = 20,
   parameter int DEN_W = 15
) (
   input  logic                              clock,
   input  bgtc_pkg::div_cmd_type             div_cmd,
   input  logic [REM_W-1:0]                  rem_load,
   input  logic [DEN_W-1:0]                  den_load,
   output logic                              rem_ge,
   output logic [bgtc_pkg::RATIO_W-1:0]      quot
);

   logic [REM_W-1:0]             rem_ff, rem_in;
   logic [DEN_W-1:0]             den_ff, den_in;
   logic [bgtc_pkg::RATIO_W-1:0] quot_ff, quot_in;
   logic [REM_W-1:0]             rem_diff;

   assign rem_ge   = rem_ff >= REM_W'(den_ff);
   assign rem_diff = rem_ge ? (rem_ff - REM_W'(den_ff)) : rem_ff;
   assign quot     = quot_ff;

   // Load operands, or take one subtract step
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (div_cmd.load) begin
         rem_in  = rem_load;
         den_in  = den_load;
         quot_in = '0;
      end else if (div_cmd.step) begin
         if (div_cmd.shift) begin
            rem_in  = {rem_diff[REM_W-2:0], 1'b0};
            quot_in = {quot_ff[bgtc_pkg::RATIO_W-2:0], rem_ge};
         end else if (rem_ge) begin
            rem_in  = rem_diff;
            quot_in = quot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

endmodule

### sv/bgtc_datapath.sv
`timescale 1ns / 1ps
// Datapath: accumulators, segment search, interpolation arithmetic and the
// result register. Uses bgtc_pkg and bgtc_divider; driven by bgtc_controller.
module bgtc_datapath #(
   parameter int SAMPLE_PAIRS = bgtc_pkg::SAMPLE_PAIRS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bgtc_pkg::cmd_type                cmd,
   output bgtc_pkg::status_type             status,
   input  logic [bgtc_pkg::REQ_W-1:0]       req_tdata,
   input  logic [bgtc_pkg::PCT_W-1:0]       green_thr,
   input  logic [bgtc_pkg::PCT_W-1:0]       red_thr,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bgtc_pkg::RSP_W-1:0]       rsp_tdata
);

   localparam int ACC_W = bgtc_pkg::SAMPLE_W + $clog2(SAMPLE_PAIRS);
   localparam int CNT_W = (SAMPLE_PAIRS > 1) ? $clog2(SAMPLE_PAIRS) : 1;
   localparam int REM_W = ACC_W + 4;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLE_PAIRS - 1);

   logic [bgtc_pkg::SAMPLE_W-1:0] ntc_sample, bat_sample;
   logic [ACC_W-1:0] ntc_acc_ff, ntc_acc_in, bat_acc_ff, bat_acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ACC_W-1:0] ntc_sum_ff, ntc_sum_in, bat_sum_ff, bat_sum_in;
   logic [ACC_W-1:0] ntc_total, bat_total;
   logic [ACC_W-1:0] ntc_thr [7];
   logic [ACC_W-1:0] bat_thr [6];

   logic       temp_lo_c, temp_hi_c, bat_lo_c, bat_hi_c;
   logic [2:0] seg_c, seg_sel, col_c;
   logic [ACC_W-1:0] temp_x, temp_den, bat_x_c, bat_den_c;
   logic [REM_W-1:0] temp_rem;

   logic       temp_lo_ff, temp_hi_ff;
   logic [2:0] seg_ff, col_ff;
   logic [ACC_W-1:0] bat_x_ff, bat_den_ff;
   logic [3:0] temp_q_ff;

   bgtc_pkg::div_cmd_type div_cmd;
   logic [REM_W-1:0] div_rem_load;
   logic [ACC_W-1:0] div_den_load;
   logic div_ge;
   logic [bgtc_pkg::RATIO_W-1:0] div_quot;

   logic [2:0] row_r;
   logic [3:0] wt_d;
   logic [bgtc_pkg::TEMP_W-1:0] temp_c;
   logic [bgtc_pkg::PCT_W-1:0]  t00, t01, t10, t11;
   logic signed [bgtc_pkg::ROW_W-1:0] ratio_x, dif0_x, dif1_x, row0_in, row1_in;
   logic signed [bgtc_pkg::ROW_W-1:0] row0_ff, row1_ff;
   logic signed [bgtc_pkg::BLEND_W-1:0] r0_x, r1_x, wt_x, blend_in, blend_ff;

   logic [bgtc_pkg::QUO_W-1:0]  quo_y;
   logic [bgtc_pkg::PROD_W-1:0] div5_prod;
   logic [bgtc_pkg::PROD_W-bgtc_pkg::DIV5_SH-1:0] pct_raw;
   logic [bgtc_pkg::PCT_W-1:0]  pct;
   logic green_c, red_c;

   logic rsp_valid_ff, rsp_valid_in;
   logic [bgtc_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   assign ntc_sample = req_tdata[bgtc_pkg::SAMPLE_W-1:0];
   assign bat_sample = req_tdata[bgtc_pkg::REQ_W-1:bgtc_pkg::SAMPLE_W];

   // Node thresholds scaled to the sum of a block
   for (genvar g = 0; g < 7; g++) begin : g_ntc_thr
      assign ntc_thr[g] = ACC_W'(bgtc_pkg::NTC_NODE[g]) * ACC_W'(SAMPLE_PAIRS);
   end
   for (genvar g = 0; g < 6; g++) begin : g_bat_thr
      assign bat_thr[g] = ACC_W'(bgtc_pkg::BAT_NODE[g]) * ACC_W'(SAMPLE_PAIRS);
   end

   // Accumulate one pair; on the last pair hand the sums over and restart
   assign ntc_total = ntc_acc_ff + ACC_W'(ntc_sample);
   assign bat_total = bat_acc_ff + ACC_W'(bat_sample);

   always_comb begin
      ntc_acc_in = ntc_acc_ff;
      bat_acc_in = bat_acc_ff;
      cnt_in     = cnt_ff;
      ntc_sum_in = ntc_sum_ff;
      bat_sum_in = bat_sum_ff;
      if (cmd.accumulate) begin
         if (cnt_ff == LAST_CNT) begin
            ntc_sum_in = ntc_total;
            bat_sum_in = bat_total;
            ntc_acc_in = '0;
            bat_acc_in = '0;
            cnt_in     = '0;
         end else begin
            ntc_acc_in = ntc_total;
            bat_acc_in = bat_total;
            cnt_in     = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ntc_acc_ff <= '0;
         bat_acc_ff <= '0;
         cnt_ff     <= '0;
      end else begin
         ntc_acc_ff <= ntc_acc_in;
         bat_acc_ff <= bat_acc_in;
         cnt_ff     <= cnt_in;
      end
      ntc_sum_ff <= ntc_sum_in;
      bat_sum_ff <= bat_sum_in;
   end

   // Find the thermistor segment and the battery column
   always_comb begin
      temp_lo_c = ntc_sum_ff >= ntc_thr[0];
      temp_hi_c = ntc_sum_ff <= ntc_thr[6];
      seg_c     = '0;
      for (int k = 1; k < 7; k++) begin
         if (ntc_sum_ff <= ntc_thr[k]) begin
            seg_c = seg_c + 3'd1;
         end
      end
      seg_sel  = (seg_c > bgtc_pkg::SEG_LAST) ? bgtc_pkg::SEG_LAST : seg_c;
      temp_x   = ntc_thr[seg_sel] - ntc_sum_ff;
      temp_den = ntc_thr[seg_sel] - ntc_thr[seg_sel + 3'd1];
      temp_rem = (REM_W'(temp_x) << 3) + (REM_W'(temp_x) << 1);

      bat_lo_c = bat_sum_ff >= bat_thr[0];
      bat_hi_c = bat_sum_ff <= bat_thr[5];
      col_c    = '0;
      for (int k = 1; k < 5; k++) begin
         if (bat_sum_ff < bat_thr[k]) begin
            col_c = col_c + 3'd1;
         end
      end
      bat_x_c   = bat_thr[col_c] - bat_sum_ff;
      bat_den_c = bat_thr[col_c] - bat_thr[col_c + 3'd1];
      // Ends of the range: zero, or exactly one
      if (bat_lo_c) begin
         col_c     = '0;
         bat_x_c   = '0;
         bat_den_c = ACC_W'(1);
      end else if (bat_hi_c) begin
         col_c     = bgtc_pkg::COL_LAST;
         bat_x_c   = ACC_W'(1);
         bat_den_c = ACC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.seg_load) begin
         temp_lo_ff <= temp_lo_c;
         temp_hi_ff <= temp_hi_c;
         seg_ff     <= seg_c;
         col_ff     <= col_c;
         bat_x_ff   <= bat_x_c;
         bat_den_ff <= bat_den_c;
      end
      if (cmd.bdiv_load) begin
         temp_q_ff <= div_quot[3:0];
      end
   end

   // Divider: temperature fraction first, then the voltage ratio
   always_comb begin
      div_cmd.load  = cmd.seg_load | cmd.bdiv_load;
      div_cmd.step  = cmd.tdiv_step | cmd.bdiv_step;
      div_cmd.shift = cmd.bdiv_step;
      if (cmd.seg_load) begin
         if (temp_lo_c || temp_hi_c) begin
            div_rem_load = '0;
            div_den_load = ACC_W'(1);
         end else begin
            div_rem_load = temp_rem;
            div_den_load = temp_den;
         end
      end else begin
         div_rem_load = REM_W'(bat_x_ff);
         div_den_load = bat_den_ff;
      end
   end

   bgtc_divider #(
      .REM_W (REM_W),
      .DEN_W (ACC_W)
   ) u_divider (
      .clock    (clock),
      .div_cmd  (div_cmd),
      .rem_load (div_rem_load),
      .den_load (div_den_load),
      .rem_ge   (div_ge),
      .quot     (div_quot)
   );

   // Temperature, table row and blend weight
   always_comb begin
      if (temp_lo_ff) begin
         row_r  = '0;
         wt_d   = '0;
         temp_c = bgtc_pkg::TEMP_MIN;
      end else if (temp_hi_ff) begin
         row_r  = bgtc_pkg::ROW_TOP;
         wt_d   = bgtc_pkg::WT_FULL;
         temp_c = bgtc_pkg::TEMP_MAX;
      end else begin
         row_r  = seg_ff;
         wt_d   = temp_q_ff;
         temp_c = bgtc_pkg::TEMP_MIN + bgtc_pkg::TEMP_W'(seg_ff) * bgtc_pkg::TEMP_W'(10)
                  + bgtc_pkg::TEMP_W'(temp_q_ff);
      end
   end

   // Interpolate along the voltage axis in both rows
   always_comb begin
      t00     = bgtc_pkg::CHARGE_LUT[row_r][col_ff];
      t01     = bgtc_pkg::CHARGE_LUT[row_r][col_ff + 3'd1];
      t10     = bgtc_pkg::CHARGE_LUT[row_r + 3'd1][col_ff];
      t11     = bgtc_pkg::CHARGE_LUT[row_r + 3'd1][col_ff + 3'd1];
      ratio_x = $signed(bgtc_pkg::ROW_W'(div_quot));
      dif0_x  = $signed(bgtc_pkg::ROW_W'(t01)) - $signed(bgtc_pkg::ROW_W'(t00));
      dif1_x  = $signed(bgtc_pkg::ROW_W'(t11)) - $signed(bgtc_pkg::ROW_W'(t10));
      row0_in = $signed(bgtc_pkg::ROW_W'({t00, bgtc_pkg::FRAC_W'(0)})) + ratio_x * dif0_x;
      row1_in = $signed(bgtc_pkg::ROW_W'({t10, bgtc_pkg::FRAC_W'(0)})) + ratio_x * dif1_x;
   end

   // Blend the rows by the temperature weight (scaled by ten)
   always_comb begin
      r0_x     = bgtc_pkg::BLEND_W'(row0_ff);
      r1_x     = bgtc_pkg::BLEND_W'(row1_ff);
      wt_x     = $signed(bgtc_pkg::BLEND_W'(wt_d));
      blend_in = r0_x * $signed(bgtc_pkg::BLEND_W'(10)) + wt_x * (r1_x - r0_x);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         row0_ff <= row0_in;
         row1_ff <= row1_in;
      end
      if (cmd.blend) begin
         blend_ff <= blend_in;
      end
   end

   // Drop the scale (2^17 then 5), clamp, compare against thresholds
   always_comb begin
      quo_y     = blend_ff[bgtc_pkg::BLEND_W-1] ? '0
                  : blend_ff[bgtc_pkg::BLEND_W-2:bgtc_pkg::BLEND_SH];
      div5_prod = bgtc_pkg::PROD_W'(quo_y) * bgtc_pkg::PROD_W'(bgtc_pkg::DIV5_MUL);
      pct_raw   = div5_prod[bgtc_pkg::PROD_W-1:bgtc_pkg::DIV5_SH];
      pct       = (pct_raw > (bgtc_pkg::PROD_W - bgtc_pkg::DIV5_SH)'(bgtc_pkg::PCT_MAX))
                  ? bgtc_pkg::PCT_MAX : pct_raw[bgtc_pkg::PCT_W-1:0];
      green_c   = pct > green_thr;
      red_c     = !green_c && (pct < red_thr);
   end

   // Result register: hold until the transaction completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {red_c, green_c, pct, temp_c};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = rsp_data_ff;
   assign status.last_pair = cnt_ff == LAST_CNT;
   assign status.div_ge    = div_ge;
   assign status.out_busy  = rsp_valid_ff && !rsp_tready;

endmodule

### sv/bgtc_controller.sv
`timescale 1ns / 1ps
// Controller: sequences accumulation, the two divisions, the blend and the
// hand-over to the result register. Uses bgtc_pkg; drives bgtc_datapath.
module bgtc_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  bgtc_pkg::status_type  status,
   output bgtc_pkg::cmd_type     cmd
);

   bgtc_pkg::state_type state_ff, state_in;
   logic [bgtc_pkg::STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bgtc_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         bgtc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accumulate = 1'b1;
               if (status.last_pair) begin
                  state_in = bgtc_pkg::ST_SEG;
               end
            end
         end
         bgtc_pkg::ST_SEG: begin
            cmd.seg_load = 1'b1;
            state_in     = bgtc_pkg::ST_TDIV;
         end
         bgtc_pkg::ST_TDIV: begin
            if (status.div_ge) begin
               cmd.tdiv_step = 1'b1;
            end else begin
               cmd.bdiv_load = 1'b1;
               step_in       = '0;
               state_in      = bgtc_pkg::ST_BDIV;
            end
         end
         bgtc_pkg::ST_BDIV: begin
            cmd.bdiv_step = 1'b1;
            if (step_ff == bgtc_pkg::STEP_W'(bgtc_pkg::DIV_STEPS - 1)) begin
               state_in = bgtc_pkg::ST_MUL;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         bgtc_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = bgtc_pkg::ST_BLEND;
         end
         bgtc_pkg::ST_BLEND: begin
            cmd.blend = 1'b1;
            state_in  = bgtc_pkg::ST_EMIT;
         end
         bgtc_pkg::ST_EMIT: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = bgtc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bgtc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### sv/battery_gauge_temp_compensated_core.sv
`timescale 1ns / 1ps
// Temperature-compensated battery gauge. Each request transaction carries one
// pair of 12-bit ADC codes (thermistor, battery) and is taken whenever the block
// is idle. After every SAMPLE_PAIRS pairs the block interpolates a temperature
// over seven thermistor nodes (-10..50 C), then a charge percentage from a 7x6
// table over temperature and battery voltage, and raises the green or red flag
// against the two thresholds; one response transaction follows per block of
// pairs. The last pair of a block starts a computation (segment search, the
// temperature fraction by repeated subtraction, seventeen steps of the shared
// divider for the voltage ratio, two multiply stages and the scaling) during
// which req_tready is low; a previous response still waiting in the result
// register holds the block in its last step for as long as it waits. Requests
// are taken again once the result is in the result register, even while it
// still waits. Thresholds sit at byte addresses 0 (green) and 4 (red); the user
// must write them only while the block is idle; the block itself does not enforce this.
// Depends on bgtc_pkg, bgtc_controller, bgtc_datapath.
module battery_gauge_temp_compensated_core #(
   parameter int SAMPLE_PAIRS = bgtc_pkg::SAMPLE_PAIRS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // fields from bit 0: ntc_sample[11:0], battery_sample[23:12]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bgtc_pkg::REQ_W-1:0]         req_tdata,
   // fields from bit 0: temperature_c[6:0], charge_percent[13:7],
   // green_led[14], red_led[15]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bgtc_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bgtc_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [bgtc_pkg::DATA_W-1:0]        csr_pwdata,
   output logic [bgtc_pkg::DATA_W-1:0]        csr_prdata,
   output logic                               csr_pready
);

   bgtc_pkg::cmd_type    cmd;
   bgtc_pkg::status_type status;

   logic [bgtc_pkg::PCT_W-1:0] green_thr_ff, green_thr_in, red_thr_ff, red_thr_in;
   logic csr_wr;

   // Register port: no wait states
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      green_thr_in = green_thr_ff;
      red_thr_in   = red_thr_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            bgtc_pkg::CSR_GREEN: green_thr_in = csr_pwdata[bgtc_pkg::PCT_W-1:0];
            bgtc_pkg::CSR_RED:   red_thr_in   = csr_pwdata[bgtc_pkg::PCT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         green_thr_ff <= bgtc_pkg::GREEN_RST;
         red_thr_ff   <= bgtc_pkg::RED_RST;
      end else begin
         green_thr_ff <= green_thr_in;
         red_thr_ff   <= red_thr_in;
      end
   end

   // Read back
   always_comb begin
      unique case (csr_paddr[2])
         bgtc_pkg::CSR_GREEN: csr_prdata = bgtc_pkg::DATA_W'(green_thr_ff);
         bgtc_pkg::CSR_RED:   csr_prdata = bgtc_pkg::DATA_W'(red_thr_ff);
         default:             csr_prdata = '0;
      endcase
   end

   bgtc_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bgtc_datapath #(
      .SAMPLE_PAIRS (SAMPLE_PAIRS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .green_thr  (green_thr_ff),
      .red_thr    (red_thr_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A result is only loaded when the result register is free
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("result loaded over a pending response");

   // Accumulation happens only on an accepted request transaction
   a_acc_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.accumulate |-> (req_tvalid && req_tready))
      else $error("accumulator advanced without a transaction");

   // Charge stays within 0..100
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[13:7] <= bgtc_pkg::PCT_MAX))
      else $error("charge percent above 100");

   // Green and red never light together
   a_led_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[14] && rsp_tdata[15]))
      else $error("both LED flags set");

   // A taken response without a new result leaves the register empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !cmd.emit) |=> !rsp_tvalid)
      else $error("response repeated");

endmodule
